// File: design/ldfd_pkg.sv
`default_nettype none

package ldfd_pkg;

	localparam logic [7:0] SYNC_FIRST = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;

	// Header is five bytes; the first four are stored, the fifth is used live.
	localparam int HEADER_BYTES = 5;
	localparam logic [2:0] HDR_LAST_IDX = 3'(HEADER_BYTES - 1);

	localparam logic [7:0] RESET_VERSION = 8'd1;
	localparam logic [15:0] RESET_TOPIC_LIMIT = 16'd64;
	localparam logic [15:0] RESET_PAYLOAD_LIMIT = 16'd2048;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_VERSION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOPIC_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_TOPIC = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_VERSION = 2'd1;
	localparam logic [1:0] ERR_TOPIC_LEN = 2'd2;
	localparam logic [1:0] ERR_PAYLOAD_LEN = 2'd3;

	typedef struct packed {
		logic [7:0] expected_version;
		logic [15:0] topic_limit;
		logic [15:0] payload_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [15:0] topic_count;
		logic [15:0] payload_count;
		logic [1:0] fault_code;
		logic frame_end;
	} result_t;

endpackage

`default_nettype wire

// File: design/ldfd_cfg.sv
`default_nettype none

module ldfd_cfg
	import ldfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= RESET_VERSION;
			cfg_q.topic_limit <= RESET_TOPIC_LIMIT;
			cfg_q.payload_limit <= RESET_PAYLOAD_LIMIT;
		end else if (cfg_we) begin
			// Writes to an index past the register list are dropped.
			unique case (cfg_index)
				REG_VERSION: cfg_q.expected_version <= cfg_data[7:0];
				REG_TOPIC_LIMIT: cfg_q.topic_limit <= cfg_data;
				REG_PAYLOAD_LIMIT: cfg_q.payload_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: design/ldfd_in_stage.sv
`default_nettype none

module ldfd_in_stage
	import ldfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic advance,
	output logic valid_s1,
	output logic [7:0] byte_s1
);

	logic valid_q;
	logic [7:0] byte_q;

	assign in_ready = !valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_q <= in_byte;
		end
	end

	assign valid_s1 = valid_q;
	assign byte_s1 = byte_q;

endmodule

`default_nettype wire

// File: design/ldfd_parser.sv
`default_nettype none

module ldfd_parser
	import ldfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [7:0] byte_s1,
	input wire cfg_t cfg,
	output logic res_valid,
	output result_t res
);

	localparam logic [2:0] PH_HUNT1 = 3'd0;
	localparam logic [2:0] PH_HUNT2 = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_TOPIC = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [2:0] hidx_q, hidx_d;
	logic [15:0] topic_total_q, topic_total_d;
	logic [15:0] payload_total_q, payload_total_d;
	logic [15:0] topic_seen_q, topic_seen_d;
	logic [15:0] payload_seen_q, payload_seen_d;
	logic [7:0] hdr_store_q [4];
	logic hdr_we;

	logic [7:0] hdr_version;
	logic [15:0] hdr_topic_len;
	logic [15:0] hdr_payload_len;
	logic [1:0] hdr_err;
	logic [15:0] topic_seen_inc;
	logic [15:0] payload_seen_inc;

	assign hdr_version = hdr_store_q[0];
	assign hdr_topic_len = {hdr_store_q[1], hdr_store_q[2]};
	assign hdr_payload_len = {hdr_store_q[3], byte_s1};
	assign topic_seen_inc = topic_seen_q + 16'd1;
	assign payload_seen_inc = payload_seen_q + 16'd1;

	// Only the first failing check is reported: version, topic, payload.
	always_comb begin
		if (cfg.expected_version != 8'd0 && hdr_version != cfg.expected_version) begin
			hdr_err = ERR_VERSION;
		end else if (hdr_topic_len > cfg.topic_limit) begin
			hdr_err = ERR_TOPIC_LEN;
		end else if (hdr_payload_len > cfg.payload_limit) begin
			hdr_err = ERR_PAYLOAD_LEN;
		end else begin
			hdr_err = ERR_NONE;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hidx_d = hidx_q;
		topic_total_d = topic_total_q;
		payload_total_d = payload_total_q;
		topic_seen_d = topic_seen_q;
		payload_seen_d = payload_seen_q;
		hdr_we = 1'b0;
		res_valid = 1'b0;
		res = '0;
		unique case (phase_q)
			PH_HUNT1: begin
				if (byte_s1 == SYNC_FIRST) begin
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				// A repeated first sync byte keeps waiting for the second one.
				if (byte_s1 == SYNC_SECOND) begin
					phase_d = PH_HEADER;
					hidx_d = 3'd0;
				end else if (byte_s1 != SYNC_FIRST) begin
					phase_d = PH_HUNT1;
				end
			end
			PH_HEADER: begin
				if (hidx_q < HDR_LAST_IDX) begin
					hdr_we = 1'b1;
					hidx_d = hidx_q + 3'd1;
				end else begin
					res_valid = 1'b1;
					phase_d = PH_HUNT1;
					hidx_d = 3'd0;
					topic_total_d = 16'd0;
					payload_total_d = 16'd0;
					topic_seen_d = 16'd0;
					payload_seen_d = 16'd0;
					if (hdr_err != ERR_NONE) begin
						res.kind = KIND_ERROR;
						res.fault_code = hdr_err;
						res.frame_end = 1'b1;
					end else begin
						res.kind = KIND_HEADER;
						res.topic_count = hdr_topic_len;
						res.payload_count = hdr_payload_len;
						if (hdr_topic_len != 16'd0 || hdr_payload_len != 16'd0) begin
							topic_total_d = hdr_topic_len;
							payload_total_d = hdr_payload_len;
							phase_d = (hdr_topic_len != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
						end else begin
							// An empty frame ends on its last header byte.
							res.frame_end = 1'b1;
						end
					end
				end
			end
			PH_TOPIC: begin
				res_valid = 1'b1;
				res.kind = KIND_TOPIC;
				res.data_byte = byte_s1;
				topic_seen_d = topic_seen_inc;
				if (topic_seen_inc >= topic_total_q) begin
					if (payload_total_q == 16'd0) begin
						res.frame_end = 1'b1;
						phase_d = PH_HUNT1;
						hidx_d = 3'd0;
						topic_total_d = 16'd0;
						payload_total_d = 16'd0;
						topic_seen_d = 16'd0;
						payload_seen_d = 16'd0;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res.kind = KIND_PAYLOAD;
				res.data_byte = byte_s1;
				payload_seen_d = payload_seen_inc;
				if (payload_seen_inc >= payload_total_q) begin
					res.frame_end = 1'b1;
					phase_d = PH_HUNT1;
					hidx_d = 3'd0;
					topic_total_d = 16'd0;
					payload_total_d = 16'd0;
					topic_seen_d = 16'd0;
					payload_seen_d = 16'd0;
				end
			end
			default: begin
				phase_d = PH_HUNT1;
				hidx_d = 3'd0;
				topic_total_d = 16'd0;
				payload_total_d = 16'd0;
				topic_seen_d = 16'd0;
				payload_seen_d = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			hidx_q <= 3'd0;
			topic_total_q <= 16'd0;
			payload_total_q <= 16'd0;
			topic_seen_q <= 16'd0;
			payload_seen_q <= 16'd0;
		end else if (step) begin
			phase_q <= phase_d;
			hidx_q <= hidx_d;
			topic_total_q <= topic_total_d;
			payload_total_q <= payload_total_d;
			topic_seen_q <= topic_seen_d;
			payload_seen_q <= payload_seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hdr_we) begin
			hdr_store_q[hidx_q[1:0]] <= byte_s1;
		end
	end

endmodule

`default_nettype wire

// File: design/ldfd_out_stage.sv
`default_nettype none

module ldfd_out_stage
	import ldfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire logic load_valid,
	input wire result_t load_res,
	output logic out_valid,
	output result_t out_res
);

	logic valid_s2;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			res_s2 <= load_res;
		end
	end

	assign out_valid = valid_s2;
	assign out_res = res_s2;

endmodule

`default_nettype wire

// File: design/length_prefixed_frame_deframer_core.sv
// Length-prefixed frame deframer.
// Input channel: one stream word per in_valid/in_ready handshake on stream_byte.
// Output channel: zero or one result word per input word, on out_valid/out_ready,
// carrying kind, data_byte, topic_count, payload_count, fault_code and frame_end.
// The block hunts for the sync pair A5 5A, reads a five-byte header (version,
// topic length, payload length, both big-endian), reports acceptance or an
// error, then passes topic and payload words through, marking the frame's last.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 version, 1 topic limit, 2 payload limit); write only while idle.
// An accepted input word passes through the input register, then the result
// register, before its result is shown on the output.
// Throughput: one word per cycle while the receiver takes results; the only state
// carried word to word is the phase and the counters, updated by a single compare-and-increment.
// Reset: registers return to version 1, topic limit 64, payload limit 2048,
// and the parser hunts for sync. When the receiver stalls, the result is held
// and the input register fills, after which in_ready drops.
`default_nettype none

module length_prefixed_frame_deframer_core
	import ldfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] stream_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [15:0] topic_count,
	output logic [15:0] payload_count,
	output logic [1:0] fault_code,
	output logic frame_end
);

	cfg_t cfg;
	logic advance;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic step;
	logic res_valid;
	result_t res;
	result_t out_res;

	// The result register can take a new word when empty or being drained.
	assign advance = !out_valid || out_ready;
	assign step = valid_s1 && advance;

	ldfd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	ldfd_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(stream_byte),
		.advance(advance),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1)
	);

	ldfd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.byte_s1(byte_s1),
		.cfg(cfg),
		.res_valid(res_valid),
		.res(res)
	);

	ldfd_out_stage u_out_stage (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.load_valid(valid_s1 && res_valid),
		.load_res(res),
		.out_valid(out_valid),
		.out_res(out_res)
	);

	assign kind = out_res.kind;
	assign data_byte = out_res.data_byte;
	assign topic_count = out_res.topic_count;
	assign payload_count = out_res.payload_count;
	assign fault_code = out_res.fault_code;
	assign frame_end = out_res.frame_end;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

	a_error_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> frame_end && fault_code != ERR_NONE)
		else $error("header error result without frame end or error code");
`endif

endmodule

`default_nettype wire

// File: verif/length_prefixed_frame_deframer_core_tb.sv
module length_prefixed_frame_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ldfd_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LATENCY_PAD = 4;
	localparam int DRAIN_LIMIT = 500;
	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_PRINTED = 40;
	localparam int WORDS_PER_PHASE = 340;
	localparam int DIRECTED_ROWS = 31;
	localparam result_t NO_RESULT = '0;

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		IN_HEADER,
		IN_TOPIC,
		IN_PAYLOAD
	} parse_phase_e;

	typedef struct packed {
		logic [7:0] word;
		logic typed;
		result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] stream_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [15:0] topic_count;
	logic [15:0] payload_count;
	logic [1:0] fault_code;
	logic frame_end;

	// Parser mirror and its copy of the registers.
	parse_phase_e parse_phase;
	logic [2:0] hdr_taken;
	logic [7:0] hdr_bytes [4];
	logic [15:0] topic_len, payload_len, topic_done, payload_done;
	logic [7:0] cfg_version;
	logic [15:0] cfg_topic_max, cfg_payload_max;

	result_t pending_results [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int frame_words = 0;

	// Typed rows run under the reset limits: version 1, topic 64, payload 2048.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// A5 followed by an ordinary word drops back to the first hunt.
		'{8'hA5, 1'b0, '0}, '{8'h3C, 1'b0, '0},
		// A repeated A5 keeps the hunt armed; an empty frame ends on its header.
		'{8'hA5, 1'b0, '0}, '{8'hA5, 1'b0, '0}, '{8'h5A, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_HEADER, 8'h00, 16'h0000, 16'h0000, ERR_NONE, 1'b1}},
		// Version zero does not match, and it is checked before the lengths.
		'{8'hA5, 1'b0, '0}, '{8'h5A, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1, '{KIND_ERROR, 8'h00, 16'h0000, 16'h0000, ERR_VERSION, 1'b1}},
		// Topic length one past the limit.
		'{8'hA5, 1'b0, '0}, '{8'h5A, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h41, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 16'h0000, 16'h0000, ERR_TOPIC_LEN, 1'b1}},
		// Topic exactly at its limit, payload one past its limit.
		'{8'hA5, 1'b0, '0}, '{8'h5A, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h40, 1'b0, '0}, '{8'h08, 1'b0, '0},
		'{8'h01, 1'b1, '{KIND_ERROR, 8'h00, 16'h0000, 16'h0000, ERR_PAYLOAD_LEN, 1'b1}}
	};

	length_prefixed_frame_deframer_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		// Printing stops after the first few dozen so a broken run stays readable.
		if (mismatches < MAX_PRINTED)
			$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic void restart_hunt();
		parse_phase = HUNT_FIRST;
		hdr_taken = '0;
		topic_len = '0;
		payload_len = '0;
		topic_done = '0;
		payload_done = '0;
	endfunction

	function automatic bit deframe_word(input logic [7:0] b, output result_t res);
		logic [15:0] tlen, plen;
		logic [1:0] err;
		res = NO_RESULT;
		deframe_word = 1'b0;
		case (parse_phase)
			HUNT_FIRST: begin
				if (b == SYNC_FIRST)
					parse_phase = HUNT_SECOND;
			end
			HUNT_SECOND: begin
				if (b == SYNC_SECOND) begin
					parse_phase = IN_HEADER;
					hdr_taken = '0;
				end else if (b != SYNC_FIRST) begin
					parse_phase = HUNT_FIRST;
				end
			end
			IN_HEADER: begin
				if (hdr_taken < HDR_LAST_IDX) begin
					hdr_bytes[hdr_taken[1:0]] = b;
					hdr_taken = hdr_taken + 3'd1;
				end else begin
					// The low payload length word is used as it arrives.
					tlen = {hdr_bytes[1], hdr_bytes[2]};
					plen = {hdr_bytes[3], b};
					if (cfg_version != 8'h00 && hdr_bytes[0] != cfg_version)
						err = ERR_VERSION;
					else if (tlen > cfg_topic_max)
						err = ERR_TOPIC_LEN;
					else if (plen > cfg_payload_max)
						err = ERR_PAYLOAD_LEN;
					else
						err = ERR_NONE;
					deframe_word = 1'b1;
					if (err != ERR_NONE) begin
						res.kind = KIND_ERROR;
						res.fault_code = err;
						res.frame_end = 1'b1;
						restart_hunt();
					end else begin
						res.kind = KIND_HEADER;
						res.topic_count = tlen;
						res.payload_count = plen;
						hdr_taken = '0;
						topic_len = tlen;
						payload_len = plen;
						topic_done = '0;
						payload_done = '0;
						if (tlen != 16'd0) begin
							parse_phase = IN_TOPIC;
						end else if (plen != 16'd0) begin
							parse_phase = IN_PAYLOAD;
						end else begin
							res.frame_end = 1'b1;
							restart_hunt();
						end
					end
				end
			end
			IN_TOPIC: begin
				topic_done = topic_done + 16'd1;
				res.kind = KIND_TOPIC;
				res.data_byte = b;
				deframe_word = 1'b1;
				if (topic_done >= topic_len) begin
					if (payload_len == 16'd0) begin
						res.frame_end = 1'b1;
						restart_hunt();
					end else begin
						parse_phase = IN_PAYLOAD;
					end
				end
			end
			IN_PAYLOAD: begin
				payload_done = payload_done + 16'd1;
				res.kind = KIND_PAYLOAD;
				res.data_byte = b;
				deframe_word = 1'b1;
				if (payload_done >= payload_len) begin
					res.frame_end = 1'b1;
					restart_hunt();
				end
			end
			default: begin
				restart_hunt();
			end
		endcase
	endfunction

	// Never 5A, so noise alone cannot complete a sync pair.
	function automatic logic [7:0] noise_word();
		logic [7:0] b;
		b = 8'($urandom);
		return (b == SYNC_SECOND) ? SYNC_FIRST : b;
	endfunction

	function automatic logic [15:0] pick_length(input logic [15:0] lim);
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 16'($urandom_range(0, 5));
		if (pick == 6)
			return (lim == 16'hFFFF) ? lim : lim + 16'd1;
		if (pick == 7)
			return lim;
		if (pick == 8)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic send_word(input logic [7:0] b, input logic typed, input result_t want);
		result_t res;
		bit has_result;
		while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		frame_words++;
		has_result = deframe_word(b, res);
		if (typed) begin
			res = want;
			has_result = 1'b1;
		end
		if (has_result)
			pending_results.push_back(res);
	endtask

	task automatic send_frame();
		logic [7:0] ver;
		logic [15:0] tlen, plen;
		int unsigned body;
		bit passes;
		repeat ($urandom_range(0, 2))
			send_word(noise_word(), 1'b0, NO_RESULT);
		send_word(SYNC_FIRST, 1'b0, NO_RESULT);
		send_word(SYNC_SECOND, 1'b0, NO_RESULT);
		ver = ($urandom_range(0, 9) < 8 && cfg_version != 8'h00) ? cfg_version : 8'($urandom);
		tlen = pick_length(cfg_topic_max);
		plen = pick_length(cfg_payload_max);
		passes = (cfg_version == 8'h00 || ver == cfg_version)
			&& tlen <= cfg_topic_max && plen <= cfg_payload_max;
		body = passes ? 32'(tlen) + 32'(plen) : 0;
		// Long accepted frames are cut down; shorter lengths still pass the checks.
		if (body > 40) begin
			tlen &= 16'h000F;
			plen &= 16'h000F;
			body = 32'(tlen) + 32'(plen);
		end
		send_word(ver, 1'b0, NO_RESULT);
		send_word(tlen[15:8], 1'b0, NO_RESULT);
		send_word(tlen[7:0], 1'b0, NO_RESULT);
		send_word(plen[15:8], 1'b0, NO_RESULT);
		send_word(plen[7:0], 1'b0, NO_RESULT);
		repeat (body)
			send_word(8'($urandom), 1'b0, NO_RESULT);
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_VERSION: cfg_version = value[7:0];
			REG_TOPIC_LIMIT: cfg_topic_max = value;
			REG_PAYLOAD_LIMIT: cfg_payload_max = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [7:0] ver, input logic [15:0] tmax,
			input logic [15:0] pmax);
		// Upper data bits of the version write must be dropped.
		put_reg(REG_VERSION, {8'hC3, ver});
		put_reg(REG_TOPIC_LIMIT, tmax);
		put_reg(REG_PAYLOAD_LIMIT, pmax);
		put_reg(REG_UNUSED, 16'hFFFF);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int gap, input int stall);
		send_gap_pct = gap;
		stall_pct = stall;
		frame_words = 0;
		while (frame_words < WORDS_PER_PHASE) begin
			if ($urandom_range(0, 99) < 85)
				send_frame();
			else
				repeat ($urandom_range(1, 6)) send_word(noise_word(), 1'b0, NO_RESULT);
		end
		settle();
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (data_byte !== want.data_byte)
					report_mismatch($sformatf("data_byte %h, expected %h",
						data_byte, want.data_byte));
				if (topic_count !== want.topic_count)
					report_mismatch($sformatf("topic_count %0d, expected %0d",
						topic_count, want.topic_count));
				if (payload_count !== want.payload_count)
					report_mismatch($sformatf("payload_count %0d, expected %0d",
						payload_count, want.payload_count));
				if (fault_code !== want.fault_code)
					report_mismatch($sformatf("fault_code %0d, expected %0d",
						fault_code, want.fault_code));
				if (frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end %0d, expected %0d",
						frame_end, want.frame_end));
			end
		end
		out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		cfg_version = RESET_VERSION;
		cfg_topic_max = RESET_TOPIC_LIMIT;
		cfg_payload_max = RESET_PAYLOAD_LIMIT;
		restart_hunt();
		send_gap_pct = 15;
		stall_pct = 63;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
		settle();

		apply_settings(8'h00, 16'd3, 16'd6);
		run_phase(15, 63);
		// Only empty frames can pass here.
		apply_settings(8'hFF, 16'h0000, 16'h0000);
		run_phase(63, 15);
		apply_settings(8'h5A, 16'hFFFF, 16'hFFFF);
		run_phase(0, 0);

		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				pending_results.size()));
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
